### rtl/asrf_pkg.sv
`timescale 1ns / 1ps

package asrf_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 11;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 1;

  // Defaults for the ring.
  localparam int RING_DEPTH_DEFAULT = 1024;
  localparam logic [SIZE_W-1:0] RING_SIZE_RESET = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_EN = 1'b1;

  // Operation codes carried by one input beat.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic respond;
  } ctrl_cmd_t;

endpackage

### rtl/audio_sample_ring_fifo_unit.sv
`timescale 1ns / 1ps
// Audio sample ring FIFO.
// Input: pulse start with op, sample_in and burst_last while busy is low;
// the beat is accepted at that edge. op selects push, pull, clear or query.
// Output: one result beat per input beat, marked by done for exactly one
// cycle, in the cycle right after the accept edge. It carries
// the byte-swapped pulled sample, sample_valid, push_accepted, the free
// space after the operation and end_of_burst. The receiver cannot stall.
// busy is high during the result cycle, which covers the registered read of
// the sample memory; no new beat is accepted while busy is high.
// Configuration: cfg_wen, cfg_index and cfg_data write ring_size (index 0) or
// stream_enable (index 1); the user must write only while the block is idle,
// which it does not enforce. A size write or a stream_enable rise empties the ring.
// Reset (rst, synchronous): the ring is empty, ring_size is 1024 and
// streaming is off, so pushes are dropped, pulls return zero and free space
// reads zero until stream_enable is written to one. The memory contents are
// not cleared; entries are only read after they were written.

module audio_sample_ring_fifo_unit import asrf_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic [OP_W-1:0]      op,
  input  logic [SAMPLE_W-1:0]  sample_in,
  input  logic                 burst_last,
  output logic [SAMPLE_W-1:0]  sample_out,
  output logic                 sample_valid,
  output logic                 push_accepted,
  output logic [SIZE_W-1:0]    free_space,
  output logic                 end_of_burst
);

  ctrl_cmd_t cmd;

  // Sequencer for one beat at a time.
  asrf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Ring pointers, memory and result registers.
  asrf_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .sample_in     (sample_in),
    .burst_last    (burst_last),
    .sample_out    (sample_out),
    .sample_valid  (sample_valid),
    .push_accepted (push_accepted),
    .free_space    (free_space),
    .end_of_burst  (end_of_burst)
  );

  assign done = cmd.respond;

  // Every accepted beat gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted beat produced no result");

  // A result strobe lasts exactly one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // A result is never both a stored pull and an accepted push.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(sample_valid && push_accepted))
    else $error("result flags both pull and push");

  // An underrun or non-pull result carries a zero sample.
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    (done && !sample_valid) |-> (sample_out == '0))
    else $error("non-pull result carries sample data");

endmodule

### rtl/asrf_ctrl.sv
`timescale 1ns / 1ps

module asrf_ctrl import asrf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. A beat executes at its accept edge and its
  // result is presented in the following cycle.
  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    cmd.exec    = 1'b0;
    cmd.respond = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.exec   = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        busy        = 1'b1;
        cmd.respond = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/asrf_datapath.sv
`timescale 1ns / 1ps

module asrf_datapath import asrf_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic [OP_W-1:0]      op,
  input  logic [SAMPLE_W-1:0]  sample_in,
  input  logic                 burst_last,
  output logic [SAMPLE_W-1:0]  sample_out,
  output logic                 sample_valid,
  output logic                 push_accepted,
  output logic [SIZE_W-1:0]    free_space,
  output logic                 end_of_burst
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CMP_W = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;

  // Configuration registers.
  logic [SIZE_W-1:0] ring_size;
  logic              stream_enable;

  // Ring pointers and occupancy.
  logic [IDX_W-1:0]  read_index;
  logic [IDX_W-1:0]  write_index;
  logic [SIZE_W-1:0] fill_count;
  logic [IDX_W-1:0]  read_index_next;
  logic [IDX_W-1:0]  write_index_next;
  logic [SIZE_W-1:0] fill_count_next;

  // Sample memory and its registered read port.
  logic [SAMPLE_W-1:0] sample_store [RING_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;

  // Result registers.
  logic              res_valid;
  logic              res_accepted;
  logic [SIZE_W-1:0] res_free;
  logic              res_last;

  logic [SIZE_W-1:0] eff_size;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  rd_inc;
  logic [CMP_W-1:0]  wr_inc;
  logic [IDX_W-1:0]  rd_adv;
  logic [IDX_W-1:0]  wr_adv;
  logic              ring_full;
  logic              ring_empty;
  logic              do_push;
  logic              do_pull;
  logic              do_clear;
  logic [SIZE_W-1:0] free_next;

  // Effective ring size: zero acts as one, and sizes above the memory clamp.
  always_comb begin
    if (ring_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(ring_size) > 32'(RING_DEPTH)) begin
      eff_size = SIZE_W'(RING_DEPTH);
    end else begin
      eff_size = ring_size;
    end
  end

  // Pointer advance with wrap at the effective size.
  assign size_ext = CMP_W'(eff_size);
  assign rd_inc   = CMP_W'(read_index) + CMP_W'(1);
  assign wr_inc   = CMP_W'(write_index) + CMP_W'(1);
  assign rd_adv   = (rd_inc >= size_ext) ? '0 : rd_inc[IDX_W-1:0];
  assign wr_adv   = (wr_inc >= size_ext) ? '0 : wr_inc[IDX_W-1:0];

  assign ring_full  = (fill_count >= eff_size);
  assign ring_empty = (fill_count == '0);

  // Decode the operation of the beat being accepted.
  always_comb begin
    do_push  = 1'b0;
    do_pull  = 1'b0;
    do_clear = 1'b0;
    case (op_t'(op))
      OP_PUSH:  do_push  = cmd.exec && stream_enable && !ring_full;
      OP_PULL:  do_pull  = cmd.exec && stream_enable && !ring_empty;
      OP_CLEAR: do_clear = cmd.exec && stream_enable;
      OP_QUERY: do_clear = 1'b0;
      default:  do_clear = 1'b0;
    endcase
  end

  // Next pointer and count values for the beat.
  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    fill_count_next  = fill_count;
    if (do_clear) begin
      read_index_next  = '0;
      write_index_next = '0;
      fill_count_next  = '0;
    end else if (do_push) begin
      write_index_next = wr_adv;
      fill_count_next  = fill_count + SIZE_W'(1);
    end else if (do_pull) begin
      read_index_next  = rd_adv;
      fill_count_next  = fill_count - SIZE_W'(1);
    end
  end

  // Free space after the beat; zero while streaming is off.
  always_comb begin
    free_next = '0;
    if (stream_enable && (eff_size > fill_count_next)) begin
      free_next = eff_size - fill_count_next;
    end
  end

  // Control state: configuration, pointers and count. A size write or an
  // enable rising from zero empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size     <= RING_SIZE_RESET;
      stream_enable <= 1'b0;
      read_index    <= '0;
      write_index   <= '0;
      fill_count    <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_RING_SIZE: begin
          ring_size   <= cfg_data;
          read_index  <= '0;
          write_index <= '0;
          fill_count  <= '0;
        end
        CFG_STREAM_EN: begin
          stream_enable <= cfg_data[0];
          if (cfg_data[0] && !stream_enable) begin
            read_index  <= '0;
            write_index <= '0;
            fill_count  <= '0;
          end
        end
        default: begin
          stream_enable <= stream_enable;
        end
      endcase
    end else begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      fill_count  <= fill_count_next;
    end
  end

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_push) begin
      sample_store[write_index] <= sample_in;
    end
    if (cmd.exec) begin
      rd_data <= sample_store[read_index];
    end
  end

  // Result fields captured at the accept edge.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_valid    <= do_pull;
      res_accepted <= do_push;
      res_free     <= free_next;
      res_last     <= burst_last;
    end
  end

  // Result beat, pulled sample byte-swapped for the mixer.
  assign sample_out    = res_valid ? {rd_data[BYTE_W-1:0], rd_data[SAMPLE_W-1:BYTE_W]} : '0;
  assign sample_valid  = cmd.respond && res_valid;
  assign push_accepted = cmd.respond && res_accepted;
  assign free_space    = res_free;
  assign end_of_burst  = res_last;

endmodule
